// File: rtl/core/jesc_pkg.sv
// ----------------------------------------------------------------------------
// jesc_pkg
// Shared types and constants of the JSON string escaper: byte slots of one
// work descriptor, character codes and the hex digit lookup.
// ----------------------------------------------------------------------------
package jesc_pkg;

    // Slot layout of one descriptor, in output order:
    // opening quote, flushed lone high surrogate, unit bytes, closing quote.
    localparam int JESC_SLOTS      = 11;
    localparam int SLOT_OPEN       = 0;
    localparam int SLOT_FLUSH      = 1;
    localparam int SLOT_UNIT       = 4;
    localparam int SLOT_CLOSE      = 10;

    localparam int JESC_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_HT = 8'h09;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_CR = 8'h0D;

    localparam logic [15:0] UNIT_SPACE    = 16'h0020;
    localparam logic [15:0] UNIT_ONE_MAX  = 16'h007F;
    localparam logic [15:0] UNIT_TWO_MAX  = 16'h07FF;
    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    typedef struct packed {
        logic [JESC_SLOTS-1:0]       mask;
        logic [JESC_SLOTS-1:0][7:0]  bytes;
    } jesc_desc_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = CH_ZERO + {4'd0, d};
        end
        else
        begin
            r = CH_LOWER_A + {4'd0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/jesc_front.sv
// ----------------------------------------------------------------------------
// jesc_front
// Accepts code units, tracks the held high surrogate and turns each
// transaction into a descriptor of up to eleven output byte slots.
// ----------------------------------------------------------------------------
module jesc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          code_unit,
    input  logic                 has_unit,
    input  logic                 first,
    input  logic                 last,
    output logic                 push_valid,
    input  logic                 push_ready,
    output jesc_pkg::jesc_desc_t push_desc
);
    import jesc_pkg::*;

    logic        pend_valid_reg, pend_valid_next;
    logic [9:0]  pend_bits_reg, pend_bits_next;
    logic        accept;
    logic        pv;
    logic        is_low, is_high;
    logic        flush;
    logic        new_pv;
    logic [9:0]  new_bits;
    logic [20:0] cp;
    logic [15:0] flush_cp;
    jesc_desc_t  desc;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign is_low   = (code_unit[15:10] == SURR_LOW_TAG);
    assign is_high  = (code_unit[15:10] == SURR_HIGH_TAG);
    assign cp       = SUPP_BASE + {1'b0, pend_bits_reg, code_unit[9:0]};
    assign flush_cp = {SURR_HIGH_TAG, pend_bits_reg};

    always_comb
    begin
        desc     = '0;
        pv       = pend_valid_reg && !first;
        flush    = 1'b0;
        new_pv   = pv;
        new_bits = pend_bits_reg;

        if (first)
        begin
            desc.mask[SLOT_OPEN]  = 1'b1;
            desc.bytes[SLOT_OPEN] = CH_QUOTE;
        end

        if (has_unit)
        begin
            new_pv = 1'b0;
            if (pv && is_low)
            begin
                // combine the surrogate pair into one four-byte sequence
                desc.mask[SLOT_UNIT+3:SLOT_UNIT] = 4'hF;
                desc.bytes[SLOT_UNIT]   = {5'b11110, cp[20:18]};
                desc.bytes[SLOT_UNIT+1] = {2'b10, cp[17:12]};
                desc.bytes[SLOT_UNIT+2] = {2'b10, cp[11:6]};
                desc.bytes[SLOT_UNIT+3] = {2'b10, cp[5:0]};
            end
            else
            begin
                flush = pv;
                priority if (code_unit == {8'h00, CH_QUOTE} ||
                             code_unit == {8'h00, CH_BACKSLASH})
                begin
                    desc.mask[SLOT_UNIT+1:SLOT_UNIT] = 2'b11;
                    desc.bytes[SLOT_UNIT]   = CH_BACKSLASH;
                    desc.bytes[SLOT_UNIT+1] = code_unit[7:0];
                end
                else if (code_unit == {8'h00, CTRL_BS} || code_unit == {8'h00, CTRL_FF} ||
                         code_unit == {8'h00, CTRL_LF} || code_unit == {8'h00, CTRL_CR} ||
                         code_unit == {8'h00, CTRL_HT})
                begin
                    desc.mask[SLOT_UNIT+1:SLOT_UNIT] = 2'b11;
                    desc.bytes[SLOT_UNIT] = CH_BACKSLASH;
                    unique case (code_unit[7:0])
                        CTRL_BS: desc.bytes[SLOT_UNIT+1] = CH_B;
                        CTRL_FF: desc.bytes[SLOT_UNIT+1] = CH_F;
                        CTRL_LF: desc.bytes[SLOT_UNIT+1] = CH_N;
                        CTRL_CR: desc.bytes[SLOT_UNIT+1] = CH_R;
                        default: desc.bytes[SLOT_UNIT+1] = CH_T;
                    endcase
                end
                else if (code_unit < UNIT_SPACE)
                begin
                    desc.mask[SLOT_UNIT+5:SLOT_UNIT] = 6'h3F;
                    desc.bytes[SLOT_UNIT]   = CH_BACKSLASH;
                    desc.bytes[SLOT_UNIT+1] = CH_U;
                    desc.bytes[SLOT_UNIT+2] = CH_ZERO;
                    desc.bytes[SLOT_UNIT+3] = CH_ZERO;
                    desc.bytes[SLOT_UNIT+4] = hex_char(code_unit[7:4]);
                    desc.bytes[SLOT_UNIT+5] = hex_char(code_unit[3:0]);
                end
                else if (is_high && !last)
                begin
                    // hold the high surrogate for the next unit
                    new_pv   = 1'b1;
                    new_bits = code_unit[9:0];
                end
                else if (code_unit <= UNIT_ONE_MAX)
                begin
                    desc.mask[SLOT_UNIT]  = 1'b1;
                    desc.bytes[SLOT_UNIT] = code_unit[7:0];
                end
                else if (code_unit <= UNIT_TWO_MAX)
                begin
                    desc.mask[SLOT_UNIT+1:SLOT_UNIT] = 2'b11;
                    desc.bytes[SLOT_UNIT]   = {3'b110, code_unit[10:6]};
                    desc.bytes[SLOT_UNIT+1] = {2'b10, code_unit[5:0]};
                end
                else
                begin
                    desc.mask[SLOT_UNIT+2:SLOT_UNIT] = 3'b111;
                    desc.bytes[SLOT_UNIT]   = {4'b1110, code_unit[15:12]};
                    desc.bytes[SLOT_UNIT+1] = {2'b10, code_unit[11:6]};
                    desc.bytes[SLOT_UNIT+2] = {2'b10, code_unit[5:0]};
                end
            end
        end
        else if (last && pv)
        begin
            flush  = 1'b1;
            new_pv = 1'b0;
        end

        if (flush)
        begin
            desc.mask[SLOT_FLUSH+2:SLOT_FLUSH] = 3'b111;
            desc.bytes[SLOT_FLUSH]   = {4'b1110, flush_cp[15:12]};
            desc.bytes[SLOT_FLUSH+1] = {2'b10, flush_cp[11:6]};
            desc.bytes[SLOT_FLUSH+2] = {2'b10, flush_cp[5:0]};
        end

        if (last)
        begin
            desc.mask[SLOT_CLOSE]  = 1'b1;
            desc.bytes[SLOT_CLOSE] = CH_QUOTE;
        end

        pend_valid_next = accept ? new_pv   : pend_valid_reg;
        pend_bits_next  = accept ? new_bits : pend_bits_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_bits_reg  <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_bits_reg  <= pend_bits_next;
        end
    end

    // drop transactions that produce no bytes
    assign push_valid = in_valid && (desc.mask != '0);
    assign push_desc  = desc;

endmodule

// File: rtl/core/jesc_fifo.sv
// ----------------------------------------------------------------------------
// jesc_fifo
// Short descriptor queue between the classifying front and the byte emitter.
// ----------------------------------------------------------------------------
module jesc_fifo #(
    parameter int DEPTH = jesc_pkg::JESC_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  jesc_pkg::jesc_desc_t push_desc,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output jesc_pkg::jesc_desc_t pop_desc
);
    import jesc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jesc_desc_t         mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_desc   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/jesc_back.sv
// ----------------------------------------------------------------------------
// jesc_back
// Walks the valid slots of one descriptor, lowest first, and emits one byte
// per cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module jesc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  jesc_pkg::jesc_desc_t pop_desc,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 last_of_run
);
    import jesc_pkg::*;

    jesc_desc_t             desc_reg, desc_next;
    logic [JESC_SLOTS-1:0]  rem_reg, rem_next;
    logic [JESC_SLOTS-1:0]  low_bit;
    logic [JESC_SLOTS-1:0]  rem_after;
    logic                   advance;
    logic                   emit;
    logic [7:0]             sel_byte;
    logic                   valid_reg, valid_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   last_reg, last_next;

    assign advance = !valid_reg || out_ready;
    assign emit    = advance && (rem_reg != '0);
    assign low_bit = rem_reg & (~rem_reg + 1'b1);

    always_comb
    begin
        sel_byte = '0;
        for (int i = 0; i < JESC_SLOTS; i++)
        begin
            sel_byte = sel_byte | (desc_reg.bytes[i] & {8{low_bit[i]}});
        end
    end

    always_comb
    begin
        rem_after  = emit ? (rem_reg & ~low_bit) : rem_reg;
        // load the next descriptor as the current one runs out
        pop_ready  = (rem_after == '0);
        desc_next  = desc_reg;
        rem_next   = rem_after;
        if (pop_ready && pop_valid)
        begin
            desc_next = pop_desc;
            rem_next  = pop_desc.mask;
        end

        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (advance)
        begin
            valid_next = emit;
            byte_next  = sel_byte;
            last_next  = ((rem_reg & ~low_bit) == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;

endmodule

// File: rtl/core/json_utf16_to_utf8_string_escaper_core.sv
// ----------------------------------------------------------------------------
// json_utf16_to_utf8_string_escaper_core
// UTF-16 code units in, a quoted and escaped JSON string out as UTF-8 bytes.
// ----------------------------------------------------------------------------
// Each input transaction carries one UTF-16 unit (or none, when has_unit is
// low) plus first/last flags that cause the opening and closing quotes. The
// output is one UTF-8 byte per transaction; m_tlast marks the final byte that
// a given input transaction causes, and transactions that cause no byte (a
// stored high surrogate, an empty item without flags) produce nothing. The
// output side runs at one byte per cycle while m_tready is high, and an
// input item yields one to ten bytes; the front takes a new item every
// cycle while the descriptor queue (QUEUE_DEPTH entries) has room. When the
// emitter is idle, an accepted item passes the descriptor queue, the
// descriptor register and the output byte register before its first byte.
module json_utf16_to_utf8_string_escaper_core #(
    parameter int QUEUE_DEPTH = jesc_pkg::JESC_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic [1:0]  s_tuser,   // [0] has_unit, [1] first
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // last_of_run
);
    import jesc_pkg::*;

    logic       push_valid, push_ready;
    jesc_desc_t push_desc;
    logic       pop_valid, pop_ready;
    jesc_desc_t pop_desc;

    jesc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .code_unit  (s_tdata),
        .has_unit   (s_tuser[0]),
        .first      (s_tuser[1]),
        .last       (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    jesc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    jesc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_desc    (pop_desc),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .last_of_run (m_tlast)
    );

endmodule

// File: verif/jesc_byte_checker.sv
// ----------------------------------------------------------------------------
// jesc_byte_checker
// Watches both stream channels of the JSON string escaper, predicts the
// UTF-8 bytes that every accepted code unit transaction must yield and
// compares each output transaction in order against that prediction.
// ----------------------------------------------------------------------------
module jesc_byte_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic [1:0]  s_tuser,   // [0] has_unit, [1] first
    input  logic        s_tlast,   // last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_byte
    input  logic        m_tlast,   // last_of_run
    output int          failures,
    output int          outstanding
);
    import jesc_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       tail;
    } esc_byte_t;

    esc_byte_t   expected_bytes[$];
    logic        high_held;
    logic [9:0]  high_bits;

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        return (d > 4'd9) ? 8'h57 + {4'd0, d} : 8'h30 + {4'd0, d};
    endfunction

    task automatic put(input logic [7:0] b);
        expected_bytes.push_back('{value: b, tail: 1'b0});
    endtask

    task automatic put_bmp(input logic [15:0] cp);
        if (cp <= UNIT_ONE_MAX)
        begin
            put(cp[7:0]);
        end
        else if (cp <= UNIT_TWO_MAX)
        begin
            put({3'b110, cp[10:6]});
            put({2'b10, cp[5:0]});
        end
        else
        begin
            put({4'b1110, cp[15:12]});
            put({2'b10, cp[11:6]});
            put({2'b10, cp[5:0]});
        end
    endtask

    // Emit a held high surrogate as a lone three-byte sequence.
    task automatic flush_high();
        if (high_held)
        begin
            put_bmp({SURR_HIGH_TAG, high_bits});
            high_held = 1'b0;
            high_bits = '0;
        end
    endtask

    task automatic encode_unit(input logic [15:0] u);
        logic [20:0] cp;
        if (high_held && u[15:10] == SURR_LOW_TAG)
        begin
            cp = SUPP_BASE + {1'b0, high_bits, u[9:0]};
            high_held = 1'b0;
            high_bits = '0;
            put({5'b11110, cp[20:18]});
            put({2'b10, cp[17:12]});
            put({2'b10, cp[11:6]});
            put({2'b10, cp[5:0]});
        end
        else
        begin
            flush_high();
            case (u)
                {8'h00, CH_QUOTE}, {8'h00, CH_BACKSLASH}:
                begin
                    put(CH_BACKSLASH);
                    put(u[7:0]);
                end
                {8'h00, CTRL_BS}: begin put(CH_BACKSLASH); put(CH_B); end
                {8'h00, CTRL_FF}: begin put(CH_BACKSLASH); put(CH_F); end
                {8'h00, CTRL_LF}: begin put(CH_BACKSLASH); put(CH_N); end
                {8'h00, CTRL_CR}: begin put(CH_BACKSLASH); put(CH_R); end
                {8'h00, CTRL_HT}: begin put(CH_BACKSLASH); put(CH_T); end
                default:
                begin
                    if (u < UNIT_SPACE)
                    begin
                        put(CH_BACKSLASH);
                        put(CH_U);
                        put(CH_ZERO);
                        put(CH_ZERO);
                        put(hex_digit(u[7:4]));
                        put(hex_digit(u[3:0]));
                    end
                    else if (u[15:10] == SURR_HIGH_TAG)
                    begin
                        high_held = 1'b1;
                        high_bits = u[9:0];
                    end
                    else
                    begin
                        put_bmp(u);
                    end
                end
            endcase
        end
    endtask

    task automatic predict_item(input logic [15:0] u, input logic has,
                                input logic opens, input logic closes);
        int        start_size;
        esc_byte_t tail_byte;
        start_size = expected_bytes.size();
        if (opens)
        begin
            // drop any surrogate left over from an unfinished string
            high_held = 1'b0;
            high_bits = '0;
            put(CH_QUOTE);
        end
        if (has)
        begin
            encode_unit(u);
        end
        if (closes)
        begin
            flush_high();
            put(CH_QUOTE);
        end
        if (expected_bytes.size() > start_size)
        begin
            tail_byte = expected_bytes.pop_back();
            tail_byte.tail = 1'b1;
            expected_bytes.push_back(tail_byte);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        esc_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            high_held = 1'b0;
            high_bits = '0;
            failures = 0;
            outstanding = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_item(s_tdata, s_tuser[0], s_tuser[1], s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    if (failures < 10)
                    begin
                        $display("ERROR: unexpected byte 0x%02h tlast=%0b",
                                 m_tdata, m_tlast);
                    end
                    failures++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.tail)
                    begin
                        if (failures < 10)
                        begin
                            $display("ERROR: byte expected 0x%02h tlast=%0b, got 0x%02h tlast=%0b",
                                     want.value, want.tail, m_tdata, m_tlast);
                        end
                        failures++;
                    end
                end
            end
            outstanding = expected_bytes.size();
        end
    end

endmodule

// File: verif/tb_json_utf16_to_utf8_string_escaper_core.sv
// ----------------------------------------------------------------------------
// tb_json_utf16_to_utf8_string_escaper_core
// Drives directed and random UTF-16 strings with random idle on both stream
// channels; a checker beside the core predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb_json_utf16_to_utf8_string_escaper_core;
    import jesc_pkg::*;

    localparam int ITEM_TARGET    = 165;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] code_unit
    logic [1:0]  s_tuser  = '0;    // [0] has_unit, [1] first
    logic        s_tlast  = 1'b0;  // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;          // last_of_run

    int   failures;
    int   outstanding;
    int   sent;
    int   idle_cycles;
    int   stall_left;
    logic tx_steady;
    logic rx_steady;

    json_utf16_to_utf8_string_escaper_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    jesc_byte_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 7)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_unit();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(16'h0020, 16'h007E));
            4:          return 16'($urandom_range(16'h0000, 16'h001F));
            5:          return $urandom_range(0, 1) ? {8'h00, CH_QUOTE} : {8'h00, CH_BACKSLASH};
            6:          return 16'($urandom_range(16'h0080, 16'h07FF));
            7:          return $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                                    : 16'($urandom_range(16'hE000, 16'hFFFF));
            8:          return 16'($urandom_range(16'hD800, 16'hDFFF));
            default:    return 16'($urandom);
        endcase
    endfunction

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0)
            begin
                stall_left <= idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [15:0] unit, input logic has,
                             input logic opens, input logic closes);
        int gap;
        gap = (!tx_steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tuser  <= {opens, has};
        s_tlast  <= closes;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sent++;
    endtask

    // hold the sender until every predicted byte has left the core
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic send_string(input logic broken);
        logic [15:0] units[$];
        int          len;
        logic        open_marker;
        logic        close_marker;
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
                units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            else
            begin
                units.push_back(rand_unit());
            end
        end
        if (units.size() == 0)
        begin
            send_item(16'($urandom), 1'b0, 1'b1, !broken);
        end
        else
        begin
            open_marker  = ($urandom_range(0, 3) == 0);
            close_marker = ($urandom_range(0, 3) == 0);
            if (open_marker)
            begin
                send_item(16'($urandom), 1'b0, 1'b1, 1'b0);
            end
            foreach (units[i])
            begin
                send_item(units[i], 1'b1, i == 0 && !open_marker,
                          i == units.size() - 1 && !close_marker && !broken);
            end
            if (close_marker && !broken)
            begin
                send_item(16'($urandom), 1'b0, 1'b0, 1'b1);
            end
        end
    endtask

    initial
    begin
        int strings;
        sent = 0;
        stall_left = 0;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: escapes, encoding boundaries, surrogates and markers
        send_item(16'h0000, 1'b0, 1'b1, 1'b0);
        send_item(16'h0041, 1'b1, 1'b0, 1'b0);
        send_item({8'h00, CH_QUOTE}, 1'b1, 1'b0, 1'b0);
        send_item({8'h00, CH_BACKSLASH}, 1'b1, 1'b0, 1'b0);
        send_item({8'h00, CTRL_BS}, 1'b1, 1'b0, 1'b0);
        send_item({8'h00, CTRL_FF}, 1'b1, 1'b0, 1'b0);
        send_item({8'h00, CTRL_LF}, 1'b1, 1'b0, 1'b0);
        send_item({8'h00, CTRL_CR}, 1'b1, 1'b0, 1'b0);
        send_item({8'h00, CTRL_HT}, 1'b1, 1'b0, 1'b0);
        send_item(16'h0000, 1'b1, 1'b0, 1'b0);
        send_item(16'h001F, 1'b1, 1'b0, 1'b0);
        send_item(16'h007F, 1'b1, 1'b0, 1'b0);
        send_item(16'h0080, 1'b1, 1'b0, 1'b0);
        send_item(16'h07FF, 1'b1, 1'b0, 1'b0);
        send_item(16'h0800, 1'b1, 1'b0, 1'b0);
        send_item(16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_item(16'hD800, 1'b1, 1'b0, 1'b0);
        send_item(16'hDC00, 1'b1, 1'b0, 1'b0);
        send_item(16'hDC00, 1'b1, 1'b0, 1'b0);
        send_item(16'hDBFF, 1'b1, 1'b0, 1'b0);
        send_item(16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_item(16'hDFFF, 1'b1, 1'b0, 1'b1);
        send_item(16'hD9AB, 1'b1, 1'b1, 1'b0);
        send_item(16'h1234, 1'b1, 1'b1, 1'b0);
        send_item(16'hDA00, 1'b1, 1'b0, 1'b0);
        send_item(16'h0000, 1'b0, 1'b0, 1'b1);
        send_item(16'h0000, 1'b0, 1'b1, 1'b1);
        drain();

        // random: mostly well-formed strings, some unterminated, some noise
        strings = 0;
        while (sent < ITEM_TARGET)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                end
            end
            else
            begin
                send_string($urandom_range(0, 9) == 0);
            end
            strings++;
            if (strings % 7 == 0)
            begin
                drain();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (failures == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
